[hw/rtl/tsd_pkg.sv]
// Shared constants and types for the descending tournament sorter.
package tsd_pkg;

    localparam int LEAVES_DEF     = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int DATA_W         = 16;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;   // sorted insert of the incoming value
        logic pop;   // shift toward cell 0, head leaves the chain
    } t_cell_ctl;

endpackage

[hw/rtl/tsd_cell.sv]
// One slot of the sorted chain: holds a value and its occupancy bit.
module tsd_cell #(
    parameter int VALUE_BITS = tsd_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tsd_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_BITS-1:0] i_x,
    input  logic [VALUE_BITS-1:0] i_prev_val,
    input  logic                  i_prev_full,
    input  logic                  i_prev_beats,
    input  logic [VALUE_BITS-1:0] i_next_val,
    input  logic                  i_next_full,
    output logic [VALUE_BITS-1:0] o_val,
    output logic                  o_full,
    output logic                  o_beats
);

    logic [VALUE_BITS-1:0] r_val;
    logic                  r_full;
    logic [VALUE_BITS-1:0] n_val;
    logic                  n_full;
    logic                  w_take_x;

    // A held value at least as large as the newcomer stays in place.
    assign o_beats  = r_full && (r_val >= i_x);
    assign w_take_x = !o_beats && i_prev_beats;

    always_comb begin
        n_val  = r_val;
        n_full = r_full;
        if (i_ctl.pop) begin
            n_val  = i_next_val;
            n_full = i_next_full;
        end else if (i_ctl.ins && !o_beats) begin
            if (w_take_x) begin
                n_val  = i_x;
                n_full = 1'b1;
            end else begin
                n_val  = i_prev_val;
                n_full = i_prev_full;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_full = r_full;

endmodule

[hw/rtl/tournament_sort_descending.sv]
// Descending sorter built as a chain of cells that keep the loaded values in order.
// Each input item is inserted in place into a chain of LEAVES cells,
// so the cells always hold the loaded values sorted largest first at cell 0. An item
// arriving when all LEAVES cells are occupied is dropped. Once the item marked
// last is accepted, the chain starts shifting toward cell 0 and hands out one value per
// cycle whenever the output register is empty or being taken, so the consumer can stall it.
// Input ready is low while a set is being read out; the final value is marked and leaves
// the chain empty for the next set. The output holds a registered item, so the next set may
// start loading while the last value of the previous one still waits to be taken.
module tournament_sort_descending #(
    parameter int LEAVES     = tsd_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = tsd_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [tsd_pkg::DATA_W-1:0] i_value,
    input  logic                       i_is_last,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [tsd_pkg::DATA_W-1:0] o_value_res,
    output logic                       o_is_last_res
);

    typedef enum logic {S_LOAD, S_EMIT} t_state;

    t_state                     r_state;
    logic                       r_out_valid;
    logic [tsd_pkg::DATA_W-1:0] r_value_res;
    logic                       r_is_last_res;

    logic [VALUE_BITS-1:0] w_x;
    logic [VALUE_BITS-1:0] w_val [LEAVES];
    logic [LEAVES-1:0]     w_full;
    logic [LEAVES-1:0]     w_beats;
    logic                  w_in_acc;
    logic                  w_pop;
    logic                  w_final;
    tsd_pkg::t_cell_ctl    w_ctl;

    assign w_x      = VALUE_BITS'(i_value);
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_pop    = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    // Head is the only occupied cell: this pop ends the set.
    assign w_final  = !w_full[1];

    assign w_ctl.ins = w_in_acc && !w_full[LEAVES-1];
    assign w_ctl.pop = w_pop;

    for (genvar g = 0; g < LEAVES; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_pv;
        logic                  w_pf;
        logic                  w_pb;
        logic [VALUE_BITS-1:0] w_nv;
        logic                  w_nf;

        if (g == 0) begin : g_head
            assign w_pv = '0;
            assign w_pf = 1'b0;
            assign w_pb = 1'b1;
        end else begin : g_body
            assign w_pv = w_val[g-1];
            assign w_pf = w_full[g-1];
            assign w_pb = w_beats[g-1];
        end

        if (g == LEAVES-1) begin : g_tail
            assign w_nv = '0;
            assign w_nf = 1'b0;
        end else begin : g_mid
            assign w_nv = w_val[g+1];
            assign w_nf = w_full[g+1];
        end

        tsd_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_x          (w_x),
            .i_prev_val   (w_pv),
            .i_prev_full  (w_pf),
            .i_prev_beats (w_pb),
            .i_next_val   (w_nv),
            .i_next_full  (w_nf),
            .o_val        (w_val[g]),
            .o_full       (w_full[g]),
            .o_beats      (w_beats[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc && i_is_last) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_pop) begin
                        r_out_valid   <= 1'b1;
                        r_value_res   <= tsd_pkg::DATA_W'(w_val[0]);
                        r_is_last_res <= w_final;
                        if (w_final) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_LOAD);
    assign o_out_valid   = r_out_valid;
    assign o_value_res   = r_value_res;
    assign o_is_last_res = r_is_last_res;

    // Occupied cells always form an unbroken run starting at cell 0.
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_full + LEAVES'(1)) & w_full) == '0)
        else $error("occupied cells not contiguous");

    // Head never smaller than its neighbor.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full[1] |-> (w_val[0] >= w_val[1]))
        else $error("chain out of order");

    // Readout never starts on an empty chain.
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> w_full[0])
        else $error("readout with empty chain");

    // Final pop leaves the chain empty for the next set.
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_final) |=> (w_full == '0))
        else $error("chain not cleared after set");

endmodule
